// File: design/tvbs_pkg.sv
// ----------------------------------------------------------------------------
// tvbs_pkg
// shared types and constants of the velocity box smoother
// ----------------------------------------------------------------------------
`default_nettype none

package tvbs_pkg;

    localparam int POS_W  = 32;
    localparam int STEP_W = 20;
    localparam int CNT_W  = 32;
    localparam int HWIN_W = 7;
    localparam int ANG_W  = 31;
    localparam int TAIL_W = 10;
    localparam int CIDX_W = 2;
    localparam int CDAT_W = 32;

    localparam logic [HWIN_W-1:0] HWIN_RESET = 7'd5;
    localparam logic [ANG_W-1:0]  ANG_RESET  = 31'd6554;
    localparam logic [TAIL_W-1:0] TAIL_RESET = 10'd400;

    localparam logic [CIDX_W-1:0] CFG_HALF_WINDOW = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ANG_STEP    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_TAIL_POINTS = 2'd2;

    localparam logic OP_POINT = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic signed [POS_W-1:0] alpha_in;
        logic signed [POS_W-1:0] beta_in;
        logic                    final_point;
    } in_word_t;

    typedef struct packed {
        logic [STEP_W-1:0]       step_number;
        logic signed [POS_W-1:0] alpha_out;
        logic signed [POS_W-1:0] beta_out;
        logic                    path_done;
    } out_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_DSTART,
        S_DWAIT,
        S_OUT
    } seq_state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PATH,
        PH_DRAIN
    } phase_t;

endpackage

`default_nettype wire

// File: design/tvbs_ring.sv
// ----------------------------------------------------------------------------
// tvbs_ring
// velocity sample ring, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tvbs_ring #(
    parameter int DEPTH = 127,
    parameter int AW    = 7,
    parameter int DW    = 64
) (
    input  wire logic          aclk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] ring_mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/tvbs_div.sv
// ----------------------------------------------------------------------------
// tvbs_div
// shared signed divider by the window length, two quotient bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tvbs_div #(
    parameter int SW = 40,
    parameter int WW = 7
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic signed [SW-1:0] dividend,
    input  wire logic        [WW-1:0] divisor,
    output logic                      done,
    output logic signed      [SW-1:0] quotient
);

    localparam int ITER = (SW + 1) / 2;
    localparam int MW   = 2 * ITER;
    localparam int CW   = $clog2(ITER + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [MW-1:0] mag_reg, mag_next;
    logic [WW-1:0] rem_reg, rem_next;

    logic [WW:0]   r0, r1;
    logic          ge0, ge1;
    logic [WW-1:0] rem0, rem1;
    logic [MW-1:0] mag0, mag1;
    logic [SW-1:0] abs_dvd;

    always_comb begin
        r0   = {rem_reg, mag_reg[MW-1]};
        ge0  = r0 >= {1'b0, divisor};
        rem0 = ge0 ? WW'(r0 - {1'b0, divisor}) : WW'(r0);
        mag0 = {mag_reg[MW-2:0], ge0};
        r1   = {rem0, mag0[MW-1]};
        ge1  = r1 >= {1'b0, divisor};
        rem1 = ge1 ? WW'(r1 - {1'b0, divisor}) : WW'(r1);
        mag1 = {mag0[MW-2:0], ge1};

        abs_dvd = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);

        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            neg_next  = dividend[SW-1];
            cnt_next  = CW'(ITER);
            mag_next  = MW'(abs_dvd);
            rem_next  = '0;
        end else if (busy_reg) begin
            mag_next = mag1;
            rem_next = rem1;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(mag_reg[SW-1:0]) : $signed(mag_reg[SW-1:0]);

endmodule

`default_nettype wire

// File: design/trajectory_velocity_box_smoother.sv
// ----------------------------------------------------------------------------
// trajectory_velocity_box_smoother
// differentiates a two-axis path, box-averages the velocity over 2h-1
// samples and integrates it back, one sample at a time through a shared divider
// ----------------------------------------------------------------------------
// sequence: a word with no result reads and writes the ring, an ignored word is
// dropped, a smoothed point adds two passes of the shared divider, the first
// point writes h pad samples; any also waits for m_ready on its last word
// throughput: one word at a time, s_ready is low until that word is finished
// reset: synchronous, clears the sequencer, phase and output valid, sets config
// defaults; the ring needs no clearing, a fill count masks unwritten entries
`default_nettype none

module trajectory_velocity_box_smoother #(
    parameter int MAX_HALF_WINDOW = 64,
    parameter int MAX_TAIL        = 1023
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire tvbs_pkg::in_word_t            s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output tvbs_pkg::out_word_t                m_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tvbs_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [tvbs_pkg::CDAT_W-1:0]   cfg_data
);

    import tvbs_pkg::*;

    localparam int DEPTH = 2 * MAX_HALF_WINDOW - 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = $clog2(2 * MAX_HALF_WINDOW);
    localparam int HW    = $clog2(MAX_HALF_WINDOW + 1);
    localparam int SW    = 33 + $clog2(2 * MAX_HALF_WINDOW);

    localparam logic signed [SW:0] SAT_HI = (SW+1)'(32'sh7fffffff);
    localparam logic signed [SW:0] SAT_LO = (SW+1)'(-32'sh7fffffff - 32'sd1);

    function automatic logic signed [POS_W-1:0] sat_diff(
        input logic signed [POS_W-1:0] a,
        input logic signed [POS_W-1:0] b
    );
        logic signed [POS_W:0] d;
        d = (POS_W+1)'(a) - (POS_W+1)'(b);
        if (d[POS_W] != d[POS_W-1]) begin
            sat_diff = d[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            sat_diff = d[POS_W-1:0];
        end
    endfunction

    seq_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;

    logic [HWIN_W-1:0] cfg_hw_reg, cfg_hw_next;
    logic [ANG_W-1:0]  cfg_ang_reg, cfg_ang_next;
    logic [TAIL_W-1:0] cfg_tail_reg, cfg_tail_next;

    logic [WW-1:0]     win_reg, win_next;
    logic [TAIL_W-1:0] tail_left_reg, tail_left_next;
    logic [HW-1:0]     pad_left_reg, pad_left_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [WW-1:0]     pushed_reg, pushed_next;
    logic [CNT_W-1:0]  emitted_reg, emitted_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  diff_reg, diff_next;
    logic [STEP_W-1:0] res_step_reg, res_step_next;
    logic              res_done_reg, res_done_next;
    logic              axis_reg, axis_next;

    logic signed [POS_W-1:0] vnew_a_reg, vnew_a_next, vnew_b_reg, vnew_b_next;
    logic signed [POS_W-1:0] last_a_reg, last_a_next, last_b_reg, last_b_next;
    logic signed [POS_W-1:0] prev_a_reg, prev_a_next, prev_b_reg, prev_b_next;
    logic signed [POS_W-1:0] acc_a_reg, acc_a_next, acc_b_reg, acc_b_next;
    logic signed [SW-1:0]    sum_a_reg, sum_a_next, sum_b_reg, sum_b_next;

    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg, m_data_next;

    logic                    in_acc;
    logic [HW-1:0]           h_c;
    logic [WW-1:0]           win_c;
    logic [TAIL_W-1:0]       tail_c;
    logic signed [POS_W-1:0] pad_a, pad_b;
    logic                    old_valid;
    logic signed [POS_W-1:0] old_a, old_b;
    logic [WW:0]             pos_inc;
    logic [2*POS_W-1:0]      rd_data;
    logic                    rd_en, wr_en, div_start, div_done;
    logic signed [SW-1:0]    div_q;
    logic signed [SW:0]      acc_sum;
    logic signed [POS_W-1:0] acc_sat;
    logic                    out_free;

    tvbs_ring #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (2 * POS_W)
    ) u_ring (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (pos_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (pos_reg),
        .wr_data ({vnew_a_reg, vnew_b_reg})
    );

    tvbs_div #(
        .SW (SW),
        .WW (WW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (axis_reg ? sum_b_reg : sum_a_reg),
        .divisor  (win_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        in_acc   = s_valid && (state_reg == S_IDLE);
        out_free = !m_valid_reg || m_ready;

        if (cfg_hw_reg == '0) begin
            h_c = HW'(1);
        end else if (32'(cfg_hw_reg) > MAX_HALF_WINDOW) begin
            h_c = HW'(MAX_HALF_WINDOW);
        end else begin
            h_c = HW'(cfg_hw_reg);
        end
        win_c  = WW'({h_c, 1'b0} - (HW+1)'(1));
        tail_c = (32'(cfg_tail_reg) > MAX_TAIL) ? TAIL_W'(MAX_TAIL) : cfg_tail_reg;
        pad_b  = $signed({1'b0, cfg_ang_reg});
        pad_a  = -pad_b;

        old_valid = pushed_reg >= win_reg;
        old_a     = old_valid ? $signed(rd_data[2*POS_W-1:POS_W]) : '0;
        old_b     = old_valid ? $signed(rd_data[POS_W-1:0]) : '0;
        pos_inc   = (WW+1)'(pos_reg) + (WW+1)'(1);

        acc_sum = (SW+1)'(axis_reg ? acc_b_reg : acc_a_reg) + (SW+1)'(div_q);
        if (acc_sum > SAT_HI) begin
            acc_sat = SAT_HI[POS_W-1:0];
        end else if (acc_sum < SAT_LO) begin
            acc_sat = SAT_LO[POS_W-1:0];
        end else begin
            acc_sat = acc_sum[POS_W-1:0];
        end

        cfg_hw_next   = cfg_hw_reg;
        cfg_ang_next  = cfg_ang_reg;
        cfg_tail_next = cfg_tail_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_HALF_WINDOW: cfg_hw_next   = cfg_data[HWIN_W-1:0];
                CFG_ANG_STEP:    cfg_ang_next  = cfg_data[ANG_W-1:0];
                CFG_TAIL_POINTS: cfg_tail_next = cfg_data[TAIL_W-1:0];
                default: begin
                end
            endcase
        end

        state_next     = state_reg;
        phase_next     = phase_reg;
        win_next       = win_reg;
        tail_left_next = tail_left_reg;
        pad_left_next  = pad_left_reg;
        pos_next       = pos_reg;
        pushed_next    = pushed_reg;
        emitted_next   = emitted_reg;
        total_next     = total_reg;
        diff_next      = diff_reg;
        res_step_next  = res_step_reg;
        res_done_next  = res_done_reg;
        axis_next      = axis_reg;
        vnew_a_next    = vnew_a_reg;
        vnew_b_next    = vnew_b_reg;
        last_a_next    = last_a_reg;
        last_b_next    = last_b_reg;
        prev_a_next    = prev_a_reg;
        prev_b_next    = prev_b_reg;
        acc_a_next     = acc_a_reg;
        acc_b_next     = acc_b_reg;
        sum_a_next     = sum_a_reg;
        sum_b_next     = sum_b_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        div_start      = 1'b0;

        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_data.operation == OP_POINT && phase_reg == PH_IDLE) begin
                        win_next       = win_c;
                        tail_left_next = tail_c;
                        pad_left_next  = h_c;
                        pos_next       = '0;
                        pushed_next    = '0;
                        emitted_next   = '0;
                        diff_next      = '0;
                        sum_a_next     = '0;
                        sum_b_next     = '0;
                        vnew_a_next    = pad_a;
                        vnew_b_next    = pad_b;
                        acc_a_next     = s_data.alpha_in;
                        acc_b_next     = s_data.beta_in;
                        prev_a_next    = s_data.alpha_in;
                        prev_b_next    = s_data.beta_in;
                        res_step_next  = '0;
                        res_done_next  = 1'b0;
                        if (s_data.final_point) begin
                            phase_next = PH_DRAIN;
                            total_next = CNT_W'(tail_c);
                        end else begin
                            phase_next = PH_PATH;
                            total_next = '0;
                        end
                        state_next = S_RD;
                    end else if (s_data.operation == OP_POINT && phase_reg == PH_PATH) begin
                        vnew_a_next = sat_diff(s_data.alpha_in, prev_a_reg);
                        vnew_b_next = sat_diff(s_data.beta_in, prev_b_reg);
                        prev_a_next = s_data.alpha_in;
                        prev_b_next = s_data.beta_in;
                        diff_next   = diff_reg + CNT_W'(1);
                        if (s_data.final_point) begin
                            phase_next = PH_DRAIN;
                            total_next = diff_reg + CNT_W'(1) + CNT_W'(tail_left_reg);
                        end
                        state_next = S_RD;
                    end else if (s_data.operation == OP_DRAIN && phase_reg == PH_DRAIN) begin
                        if (emitted_reg < total_reg) begin
                            if (tail_left_reg != '0) begin
                                tail_left_next = tail_left_reg - TAIL_W'(1);
                                vnew_a_next    = '0;
                                vnew_b_next    = '0;
                            end else begin
                                vnew_a_next = last_a_reg;
                                vnew_b_next = last_b_reg;
                            end
                            state_next = S_RD;
                        end else begin
                            phase_next    = PH_IDLE;
                            res_step_next = STEP_W'(total_reg + CNT_W'(1));
                            res_done_next = 1'b1;
                            state_next    = S_OUT;
                        end
                    end
                end
            end
            S_RD: begin
                rd_en      = 1'b1;
                state_next = S_WR;
            end
            S_WR: begin
                wr_en       = 1'b1;
                sum_a_next  = sum_a_reg + SW'(vnew_a_reg) - SW'(old_a);
                sum_b_next  = sum_b_reg + SW'(vnew_b_reg) - SW'(old_b);
                pushed_next = old_valid ? pushed_reg : pushed_reg + WW'(1);
                pos_next    = (pos_inc >= (WW+1)'(win_reg)) ? '0 : AW'(pos_inc);
                last_a_next = vnew_a_reg;
                last_b_next = vnew_b_reg;
                if (pad_left_reg != '0) begin
                    pad_left_next = pad_left_reg - HW'(1);
                    state_next    = (pad_left_reg == HW'(1)) ? S_OUT : S_RD;
                end else if (old_valid) begin
                    axis_next  = 1'b0;
                    state_next = S_DSTART;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DSTART: begin
                div_start  = 1'b1;
                state_next = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_done) begin
                    if (!axis_reg) begin
                        acc_a_next = acc_sat;
                        axis_next  = 1'b1;
                        state_next = S_DSTART;
                    end else begin
                        acc_b_next    = acc_sat;
                        emitted_next  = emitted_reg + CNT_W'(1);
                        res_step_next = STEP_W'(emitted_reg + CNT_W'(1));
                        res_done_next = 1'b0;
                        state_next    = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.step_number = res_step_reg;
                    m_data_next.alpha_out = res_done_reg ? prev_a_reg : acc_a_reg;
                    m_data_next.beta_out  = res_done_reg ? prev_b_reg : acc_b_reg;
                    m_data_next.path_done = res_done_reg;
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_IDLE;
            m_valid_reg  <= 1'b0;
            cfg_hw_reg   <= HWIN_RESET;
            cfg_ang_reg  <= ANG_RESET;
            cfg_tail_reg <= TAIL_RESET;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            m_valid_reg  <= m_valid_next;
            cfg_hw_reg   <= cfg_hw_next;
            cfg_ang_reg  <= cfg_ang_next;
            cfg_tail_reg <= cfg_tail_next;
        end
        win_reg       <= win_next;
        tail_left_reg <= tail_left_next;
        pad_left_reg  <= pad_left_next;
        pos_reg       <= pos_next;
        pushed_reg    <= pushed_next;
        emitted_reg   <= emitted_next;
        total_reg     <= total_next;
        diff_reg      <= diff_next;
        res_step_reg  <= res_step_next;
        res_done_reg  <= res_done_next;
        axis_reg      <= axis_next;
        vnew_a_reg    <= vnew_a_next;
        vnew_b_reg    <= vnew_b_next;
        last_a_reg    <= last_a_next;
        last_b_reg    <= last_b_next;
        prev_a_reg    <= prev_a_next;
        prev_b_reg    <= prev_b_next;
        acc_a_reg     <= acc_a_next;
        acc_b_reg     <= acc_b_next;
        sum_a_reg     <= sum_a_next;
        sum_b_reg     <= sum_b_next;
        m_data_reg    <= m_data_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// File: design/tvbs_checker.sv
// ----------------------------------------------------------------------------
// tvbs_checker
// port-level checks of the velocity box smoother, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tvbs_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire tvbs_pkg::out_word_t m_data
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a result never appears the cycle after an input word is taken
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared too early");

    // busy while a word is being worked on and a result is being built
    a_busy_on_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result built while idle");

endmodule

bind trajectory_velocity_box_smoother tvbs_checker u_tvbs_checker (.*);

`default_nettype wire
